FILE: src/assert_macros.svh
// Assertion macros shared by the false-color map modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is high.
`define ARFC_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ARFC_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

FILE: src/arfc_pkg.sv
// Shared types, codes and ramp tables of the false-color map.
package arfc_pkg;

  localparam int SAMPLE_BITS_DEF = 32;
  localparam int SPAN_BITS       = 8;
  localparam int CHAN_COUNT      = 3;

  localparam logic OP_RANGE = 1'b0;
  localparam logic OP_COLOR = 1'b1;

  localparam logic [1:0] LAYER_ELEVATION = 2'd0;
  localparam logic [1:0] LAYER_WATER     = 2'd1;
  localparam logic [1:0] LAYER_SURFACE   = 2'd2;

  localparam logic [31:0] NODATA_RGBA = 32'h181818FF;
  localparam logic [7:0]  ALPHA       = 8'hFF;

  typedef logic [0:CHAN_COUNT-1][SPAN_BITS-1:0] ramp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_START,
    ST_WAIT,
    ST_OUT
  } arfc_state_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic nodata;
  } range_upd_t;

  function automatic ramp_t ramp_base(input logic [1:0] layer);
    ramp_t r;
    case (layer)
      LAYER_ELEVATION: r = {8'd40, 8'd50, 8'd30};
      LAYER_WATER:     r = {8'd10, 8'd50, 8'd110};
      LAYER_SURFACE:   r = {8'd50, 8'd50, 8'd70};
      default:         r = {8'd50, 8'd50, 8'd70};
    endcase
    return r;
  endfunction

  function automatic ramp_t ramp_span(input logic [1:0] layer);
    ramp_t r;
    case (layer)
      LAYER_ELEVATION: r = {8'd180, 8'd150, 8'd90};
      LAYER_WATER:     r = {8'd20, 8'd80, 8'd130};
      LAYER_SURFACE:   r = {8'd140, 8'd110, 8'd120};
      default:         r = {8'd140, 8'd110, 8'd120};
    endcase
    return r;
  endfunction

endpackage

FILE: src/arfc_in_if.sv
// Sample request channel: valid/ready handshake with the sample fields.
interface arfc_in_if #(
  parameter int SAMPLE_BITS = arfc_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic                   first_sample;
  logic                   nodata;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, op, first_sample, nodata, sample, input ready);
  modport sink   (input valid, op, first_sample, nodata, sample, output ready);
endinterface

FILE: src/arfc_out_if.sv
// Pixel request channel: valid/ready handshake with the packed color.
interface arfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rgba;

  modport source (output valid, rgba, input ready);
  modport sink   (input valid, rgba, output ready);
endinterface

FILE: src/arfc_range.sv
// Running min/max tracker, kept in offset-binary so unsigned order is signed order.
`include "assert_macros.svh"

module arfc_range #(
  parameter int SAMPLE_BITS = arfc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  arfc_pkg::range_upd_t   upd,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic [SAMPLE_BITS-1:0] lo_b,
  output logic [SAMPLE_BITS-1:0] hi_b,
  output logic                   seen
);
  import arfc_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] SIGN_BIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [SAMPLE_BITS-1:0] s_b;
  logic                   seen_eff;

  assign s_b      = sample ^ SIGN_BIT;
  assign seen_eff = seen && !upd.first;

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_b <= SIGN_BIT;
      hi_b <= SIGN_BIT;
      seen <= 1'b0;
    end else if (upd.valid) begin
      seen <= seen_eff || !upd.nodata;
      if (!upd.nodata) begin
        if (!seen_eff) begin
          lo_b <= s_b;
          hi_b <= s_b;
        end else begin
          if (s_b < lo_b) lo_b <= s_b;
          if (s_b > hi_b) hi_b <= s_b;
        end
      end
    end
  end

  `ARFC_ASSERT(a_range_ordered, clk, rst, seen |-> (lo_b <= hi_b), "range low above high")

endmodule

FILE: src/arfc_sdiv.sv
// Scale by span, then restoring division shifting one quotient bit per cycle.
`include "assert_macros.svh"

module arfc_sdiv #(
  parameter int SAMPLE_BITS = arfc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [SAMPLE_BITS-1:0]           d,
  input  logic [SAMPLE_BITS-1:0]           den,
  input  logic [arfc_pkg::SPAN_BITS-1:0]   span,
  output logic                             done,
  output logic [arfc_pkg::SPAN_BITS-1:0]   quot
);
  import arfc_pkg::*;

  localparam int PW = SAMPLE_BITS + SPAN_BITS;
  localparam int CW = $clog2(SPAN_BITS);
  localparam logic [CW-1:0] LAST_STEP = CW'(SPAN_BITS - 1);

  logic [PW-1:0]          prod_c;
  logic [SAMPLE_BITS-1:0] rem;
  logic [SPAN_BITS-1:0]   sr;
  logic [CW-1:0]          cnt;
  logic                   busy;
  logic [SAMPLE_BITS:0]   trial;
  logic [SAMPLE_BITS:0]   diff;
  logic                   fits;

  assign prod_c = PW'(d) * PW'(span);
  assign trial  = {rem, sr[SPAN_BITS-1]};
  assign diff   = trial - {1'b0, den};
  assign fits   = !diff[SAMPLE_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= prod_c[PW-1:SPAN_BITS];
      sr   <= prod_c[SPAN_BITS-1:0];
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
      sr   <= {sr[SPAN_BITS-2:0], 1'b0};
      quot <= {quot[SPAN_BITS-2:0], fits};
    end
  end

  `ARFC_ASSERT(a_rem_below_den, clk, rst, busy |-> (rem < den), "partial remainder not below divisor")
  `ARFC_ASSERT(a_done_after_busy, clk, rst, done |-> $past(busy), "done without a running division")

endmodule

FILE: src/auto_range_false_color_map.sv
// A color request over a valid range goes through the shared divider (load with span multiply,
// 8 quotient bits, done) once per channel, 3 channels, then to the output register; a nodata
// pixel or an empty or flat range skips the divider.
// Requests are taken only in the idle state, so a new color request waits until the last pixel
// is in the output register; range requests are taken every cycle while the block is idle.
// Reset (synchronous, active high): range empty, layer_select 0, output register empty.
`include "assert_macros.svh"

module auto_range_false_color_map #(
  parameter int SAMPLE_BITS = arfc_pkg::SAMPLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_data,
  arfc_in_if.sink      samples,
  arfc_out_if.source   pixels
);
  import arfc_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] SIGN_BIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [1:0] LAST_CHAN = 2'(CHAN_COUNT - 1);

  arfc_state_t            state, state_next;
  logic [1:0]             layer_select;
  logic [1:0]             chan, chan_next;
  logic [23:0]            pix, pix_next;
  logic                   out_valid;
  logic [31:0]            out_rgba;
  logic                   out_load;
  logic                   accept;
  logic                   latch_v;
  logic [SAMPLE_BITS-1:0] v_b;
  logic [SAMPLE_BITS-1:0] d;
  logic [SAMPLE_BITS-1:0] den;
  logic [SAMPLE_BITS-1:0] d_c;
  logic [SAMPLE_BITS-1:0] den_c;
  logic                   flat_c;
  logic [SAMPLE_BITS-1:0] lo_b;
  logic [SAMPLE_BITS-1:0] hi_b;
  logic                   seen;
  range_upd_t             upd;
  logic                   div_start;
  logic                   div_done;
  logic [SPAN_BITS-1:0]   quot;
  ramp_t                  bases;
  ramp_t                  spans;

  assign accept       = samples.valid && samples.ready;
  assign upd.valid    = accept && (samples.op == OP_RANGE);
  assign upd.first    = samples.first_sample;
  assign upd.nodata   = samples.nodata;
  assign bases        = ramp_base(layer_select);
  assign spans        = ramp_span(layer_select);
  assign pixels.valid = out_valid;
  assign pixels.rgba  = out_rgba;

  arfc_range #(.SAMPLE_BITS(SAMPLE_BITS)) u_range (
    .clk    (clk),
    .rst    (rst),
    .upd    (upd),
    .sample (samples.sample),
    .lo_b   (lo_b),
    .hi_b   (hi_b),
    .seen   (seen)
  );

  arfc_sdiv #(.SAMPLE_BITS(SAMPLE_BITS)) u_sdiv (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .d     (d),
    .den   (den),
    .span  (spans[chan]),
    .done  (div_done),
    .quot  (quot)
  );

  // clamp the sample into the range and form the divisor
  always_comb begin
    den_c  = hi_b - lo_b;
    flat_c = !seen || (hi_b <= lo_b);
    if (v_b <= lo_b) begin
      d_c = '0;
    end else if (v_b >= hi_b) begin
      d_c = den_c;
    end else begin
      d_c = v_b - lo_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      chan         <= '0;
      out_valid    <= 1'b0;
      layer_select <= LAYER_ELEVATION;
    end else begin
      state <= state_next;
      chan  <= chan_next;
      if (cfg_we) layer_select <= cfg_data;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pixels.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pix <= pix_next;
    if (latch_v) v_b <= samples.sample ^ SIGN_BIT;
    if (state == ST_PREP) begin
      d   <= d_c;
      den <= den_c;
    end
    if (out_load) out_rgba <= {pix, ALPHA};
  end

  always_comb begin
    state_next    = state;
    chan_next     = chan;
    pix_next      = pix;
    samples.ready = 1'b0;
    latch_v       = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid && (samples.op == OP_COLOR)) begin
          if (samples.nodata) begin
            pix_next   = NODATA_RGBA[31:8];
            state_next = ST_OUT;
          end else begin
            latch_v    = 1'b1;
            state_next = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        chan_next = '0;
        if (flat_c) begin
          pix_next   = {bases[0], bases[1], bases[2]};
          state_next = ST_OUT;
        end else begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          pix_next = {pix[15:0], bases[chan] + quot};
          if (chan == LAST_CHAN) begin
            state_next = ST_OUT;
          end else begin
            chan_next  = chan + 1'b1;
            state_next = ST_START;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid || pixels.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `ARFC_ASSERT(a_color_to_prep, clk, rst,
    (accept && (samples.op == OP_COLOR) && !samples.nodata) |=> (state == ST_PREP),
    "color request did not start the range check")
  `ARFC_ASSERT(a_chan_bound, clk, rst,
    ((state == ST_START) || (state == ST_WAIT)) |-> (chan <= LAST_CHAN),
    "channel index out of range")

endmodule

FILE: tb/tb_auto_range_false_color_map.sv
// Testbench for auto_range_false_color_map: two-pass range and color requests against a predictor.
module tb_auto_range_false_color_map;
  import arfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] LAYER_SURFACE_ALIAS = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT = 4000;
  localparam int SEG_ITEMS = 115;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic        op;
    logic        first;
    logic        nodata;
    logic [31:0] sample;
  } sample_req_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_data;

  arfc_in_if #(.SAMPLE_BITS(32)) smp_if ();
  arfc_out_if pix_if ();

  auto_range_false_color_map #(.SAMPLE_BITS(32)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .samples  (smp_if),
    .pixels   (pix_if)
  );

  sample_req_t req_pending[$];
  logic [31:0] pixels_due[$];
  int          queued_total;
  int          accepted_total;
  int          bad_pixels;
  int          stall_cycles;
  int          tx_idle;
  int          rx_idle;
  logic        smp_taken;

  // shadow state
  logic [1:0]  layer_q;
  logic [31:0] rng_lo;
  logic [31:0] rng_hi;
  logic        rng_seen;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] ramp_color(input logic [31:0] s);
    logic [23:0]     bases;
    logic [23:0]     spans;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned v;
    longint unsigned den;
    longint unsigned d;
    longint unsigned ch;
    logic [31:0]     px;
    int              c;
    case (layer_q)
      LAYER_ELEVATION: begin
        bases = {8'd40, 8'd50, 8'd30};
        spans = {8'd180, 8'd150, 8'd90};
      end
      LAYER_WATER: begin
        bases = {8'd10, 8'd50, 8'd110};
        spans = {8'd20, 8'd80, 8'd130};
      end
      default: begin
        bases = {8'd50, 8'd50, 8'd70};
        spans = {8'd140, 8'd110, 8'd120};
      end
    endcase
    // offset binary so unsigned compare follows signed order
    lo = {32'h0, rng_lo ^ 32'h8000_0000};
    hi = {32'h0, rng_hi ^ 32'h8000_0000};
    v  = {32'h0, s ^ 32'h8000_0000};
    px = {24'h0, ALPHA};
    for (c = 0; c < 3; c++) begin
      ch = bases[23-8*c -: 8];
      if (rng_seen && hi > lo) begin
        den = hi - lo;
        if (v <= lo) d = 0;
        else if (v >= hi) d = den;
        else d = v - lo;
        ch = ch + (d * spans[23-8*c -: 8]) / den;
      end
      px[31-8*c -: 8] = ch[7:0];
    end
    return px;
  endfunction

  // predictor, scoreboard and watchdog
  always @(posedge clk) begin
    if (rst) begin
      layer_q      = LAYER_ELEVATION;
      rng_lo       = '0;
      rng_hi       = '0;
      rng_seen     = 1'b0;
      stall_cycles = 0;
      smp_taken <= 1'b0;
    end else begin
      if (cfg_we) layer_q = cfg_data;
      smp_taken <= smp_if.valid && smp_if.ready;
      if (smp_if.valid && smp_if.ready) begin
        accepted_total++;
        if (smp_if.op == OP_RANGE) begin
          if (smp_if.first_sample) rng_seen = 1'b0;
          if (!smp_if.nodata) begin
            if (!rng_seen) begin
              rng_lo   = smp_if.sample;
              rng_hi   = smp_if.sample;
              rng_seen = 1'b1;
            end else begin
              if ($signed(smp_if.sample) < $signed(rng_lo)) rng_lo = smp_if.sample;
              if ($signed(smp_if.sample) > $signed(rng_hi)) rng_hi = smp_if.sample;
            end
          end
        end else begin
          pixels_due = {pixels_due,
                        (smp_if.nodata ? NODATA_RGBA : ramp_color(smp_if.sample))};
        end
      end
      if (pix_if.valid && pix_if.ready) begin
        if (pixels_due.size() == 0) begin
          if (bad_pixels < REPORT_MAX)
            $display("%0t: unexpected pixel rgba=%08h", $realtime, pix_if.rgba);
          bad_pixels++;
        end else begin
          if (pix_if.rgba !== pixels_due[0]) begin
            if (bad_pixels < REPORT_MAX)
              $display("%0t: rgba mismatch exp=%08h act=%08h", $realtime,
                       pixels_due[0], pix_if.rgba);
            bad_pixels++;
          end
          void'(pixels_due.pop_front());
        end
      end
      if ((smp_if.valid && smp_if.ready) || (pix_if.valid && pix_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    sample_req_t r;
    if (rst) begin
      smp_if.valid <= 1'b0;
    end else if (!smp_if.valid || smp_taken) begin
      if (req_pending.size() > 0 && $urandom_range(99) >= tx_idle) begin
        r = req_pending.pop_front();
        smp_if.valid        <= 1'b1;
        smp_if.op           <= r.op;
        smp_if.first_sample <= r.first;
        smp_if.nodata       <= r.nodata;
        smp_if.sample       <= r.sample;
      end else begin
        smp_if.valid <= 1'b0;
      end
    end
  end

  // pixel receiver
  always @(negedge clk) begin
    if (rst) pix_if.ready <= 1'b0;
    else pix_if.ready <= ($urandom_range(99) >= rx_idle);
  end

  task automatic push_req(input logic op, input logic first, input logic nodata,
                          input logic [31:0] s);
    sample_req_t r;
    r.op     = op;
    r.first  = first;
    r.nodata = nodata;
    r.sample = s;
    req_pending = {req_pending, r};
    queued_total++;
  endtask

  task automatic wait_drained();
    while (accepted_total != queued_total || pixels_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_layer(input logic [1:0] layer);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= layer;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // one frame: range pass then color pass, sometimes broken or noisy
  task automatic gen_frame(output int n);
    logic [31:0] seen_vals[$];
    logic [31:0] center;
    logic [31:0] mag;
    logic [31:0] s;
    int          nr;
    int          nc;
    int          i;
    n = 0;
    center = $urandom;
    case ($urandom_range(3))
      0: mag = 32'h0000_00FF;
      1: mag = 32'h0000_FFFF;
      2: mag = 32'h00FF_FFFF;
      default: mag = 32'hFFFF_FFFF;
    endcase
    if ($urandom_range(9) == 0) begin
      push_req(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
               $urandom);
      n = 1;
      return;
    end
    nr = $urandom_range(1, 6);
    nc = $urandom_range(1, 6);
    for (i = 0; i < nr; i++) begin
      case ($urandom_range(15))
        0: s = 32'h8000_0000;
        1: s = 32'h7FFF_FFFF;
        default: s = center + ($urandom & mag);
      endcase
      if ($urandom_range(7) == 0) begin
        push_req(OP_RANGE, (i == 0) && ($urandom_range(9) != 0), 1'b1, s);
      end else begin
        push_req(OP_RANGE, (i == 0) && ($urandom_range(9) != 0), 1'b0, s);
        seen_vals = {seen_vals, s};
      end
      n++;
    end
    for (i = 0; i < nc; i++) begin
      if (seen_vals.size() > 0 && $urandom_range(2) != 0)
        s = seen_vals[$urandom_range(seen_vals.size() - 1)] + $urandom_range(8) - 4;
      else if ($urandom_range(3) == 0)
        s = $urandom;
      else
        s = center + ($urandom & mag);
      push_req(OP_COLOR, $urandom_range(3) == 0, $urandom_range(9) == 0, s);
      n++;
    end
  endtask

  initial begin
    logic [1:0] layer_plan[4];
    int         phase;
    int         seg;
    int         count;
    int         n;
    layer_plan = '{LAYER_ELEVATION, LAYER_WATER, LAYER_SURFACE, LAYER_SURFACE_ALIAS};
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_data            = LAYER_ELEVATION;
    smp_if.valid        = 1'b0;
    smp_if.op           = OP_RANGE;
    smp_if.first_sample = 1'b0;
    smp_if.nodata       = 1'b0;
    smp_if.sample       = '0;
    pix_if.ready        = 1'b0;
    queued_total        = 0;
    accepted_total      = 0;
    bad_pixels          = 0;
    tx_idle             = 15;
    rx_idle             = 88;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty range, nodata pixel
    push_req(OP_COLOR, 1'b0, 1'b0, 32'h0000_0000);
    push_req(OP_COLOR, 1'b0, 1'b1, 32'h0000_0000);
    // restart with a nodata sample leaves the range empty
    push_req(OP_RANGE, 1'b1, 1'b1, 32'h1234_5678);
    push_req(OP_COLOR, 1'b0, 1'b0, 32'h0001_0000);
    // full span range
    push_req(OP_RANGE, 1'b1, 1'b0, 32'h8000_0000);
    push_req(OP_RANGE, 1'b0, 1'b0, 32'h7FFF_FFFF);
    push_req(OP_RANGE, 1'b0, 1'b1, 32'h0000_0000);
    push_req(OP_COLOR, 1'b0, 1'b0, 32'h8000_0000);
    push_req(OP_COLOR, 1'b0, 1'b0, 32'h7FFF_FFFF);
    push_req(OP_COLOR, 1'b0, 1'b0, 32'h0000_0000);
    push_req(OP_COLOR, 1'b1, 1'b0, 32'h4000_0000);
    push_req(OP_COLOR, 1'b0, 1'b1, 32'h7FFF_FFFF);
    // flat range
    push_req(OP_RANGE, 1'b1, 1'b0, 32'h0005_0000);
    push_req(OP_RANGE, 1'b0, 1'b0, 32'h0005_0000);
    push_req(OP_COLOR, 1'b0, 1'b0, 32'h0005_0000);
    push_req(OP_COLOR, 1'b0, 1'b0, 32'h0000_0001);
    // clamping both sides, then extend the range without restart
    push_req(OP_RANGE, 1'b1, 1'b0, 32'hFFFD_0000);
    push_req(OP_RANGE, 1'b0, 1'b0, 32'h0007_0000);
    push_req(OP_RANGE, 1'b0, 1'b0, 32'h0002_0000);
    push_req(OP_COLOR, 1'b0, 1'b0, 32'hFF9C_0000);
    push_req(OP_COLOR, 1'b0, 1'b0, 32'h0064_0000);
    push_req(OP_COLOR, 1'b0, 1'b0, 32'h0001_2345);
    push_req(OP_RANGE, 1'b0, 1'b0, 32'hFFFC_0000);
    push_req(OP_COLOR, 1'b0, 1'b0, 32'h0000_0000);
    // sender holds off until every pixel is back
    wait_drained();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle = 15; rx_idle = 88; end
        1: begin tx_idle = 88; rx_idle = 15; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      for (seg = 0; seg < 4; seg++) begin
        write_layer(layer_plan[(phase + seg) % 4]);
        count = 0;
        while (count < SEG_ITEMS) begin
          gen_frame(n);
          count += n;
        end
        wait_drained();
      end
    end

    if (bad_pixels == 0 && pixels_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
